// ----- hdl/epmc_pkg.sv -----
// Shared types, codes and reset values for the encoder position move controller.
package epmc_pkg;

	// Position counter width, default.
	localparam int COUNT_BITS_DEF = 32;

	// Field widths.
	localparam int CMD_W    = 3;
	localparam int TICKS_W  = 16;
	localparam int SPEED_W  = 10;
	localparam int DUTY_W   = 8;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Stream widths.
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = CMD_W;
	localparam int M_TDATA_W = 56;

	// Register reset values.
	localparam logic [15:0]        EXT_THRESHOLD_RST = 16'd10;
	localparam logic [15:0]        STEP_TICKS_RST    = 16'd200;
	localparam logic [INDEX_W-1:0] MAX_INDEX_RST     = 4'd10;
	localparam logic [DUTY_W-1:0]  INDEX_SPEED_RST   = 8'd200;
	localparam logic [15:0]        MOVE_TIMEOUT_RST  = 16'd0;

	// Saturation limits.
	localparam logic [SPEED_W-1:0] SPEED_SAT = 10'd255;
	localparam logic [TICKS_W-1:0] TICKS_MAX = 16'hFFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_PULSE  = 3'd0,
		CMD_MOVE   = 3'd1,
		CMD_GOTO   = 3'd2,
		CMD_CANCEL = 3'd3,
		CMD_TICK   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE     = 3'd0,
		ST_DONE     = 3'd1,
		ST_TIMEOUT  = 3'd2,
		ST_REJECTED = 3'd3,
		ST_EXTERNAL = 3'd4,
		ST_AT_INDEX = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXT_THRESHOLD = 3'd0,
		REG_STEP_TICKS    = 3'd1,
		REG_MAX_INDEX     = 3'd2,
		REG_INDEX_SPEED   = 3'd3,
		REG_MOVE_TIMEOUT  = 3'd4
	} reg_idx_t;

	// Direction in which encoder pulses move the count.
	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	typedef struct packed {
		logic [15:0]        ext_threshold;
		logic [15:0]        step_ticks;
		logic [INDEX_W-1:0] max_index;
		logic [DUTY_W-1:0]  index_speed;
		logic [15:0]        move_timeout;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [TICKS_W-1:0] move_ticks;
		logic               move_dir;
		logic [SPEED_W-1:0] move_speed;
		logic [INDEX_W-1:0] target_index;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  position_index;
		logic [POS_W-1:0]    position_count;
		logic [STATUS_W-1:0] status;
		logic                busy_res;
		logic                dir_pin;
		logic [DUTY_W-1:0]   pwm_duty;
	} result_t;

	// Handshake between the input register and the core.
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

// ----- hdl/epmc_cfg.sv -----
// Configuration register file of the encoder position move controller.
module epmc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [epmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [epmc_pkg::CFG_DATA_W-1:0] cfg_data,
	output epmc_pkg::cfg_t               cfg
);
	import epmc_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register write on each transfer; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ext_threshold <= EXT_THRESHOLD_RST;
			cfg_q.step_ticks    <= STEP_TICKS_RST;
			cfg_q.max_index     <= MAX_INDEX_RST;
			cfg_q.index_speed   <= INDEX_SPEED_RST;
			cfg_q.move_timeout  <= MOVE_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_EXT_THRESHOLD: cfg_q.ext_threshold <= cfg_data;
				REG_STEP_TICKS:    cfg_q.step_ticks    <= cfg_data;
				REG_MAX_INDEX:     cfg_q.max_index     <= cfg_data[INDEX_W-1:0];
				REG_INDEX_SPEED:   cfg_q.index_speed   <= cfg_data[DUTY_W-1:0];
				REG_MOVE_TIMEOUT:  cfg_q.move_timeout  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/epmc_in_stage.sv -----
// Input register of the encoder position move controller.
module epmc_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [epmc_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [epmc_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                          advance,
	output epmc_pkg::stage_ctl_t          ctl,
	output epmc_pkg::item_t               item_s1
);
	import epmc_pkg::*;

	logic valid_s1;

	// Take a new item when the stage is empty or drains this cycle.
	assign s_tready    = !valid_s1 || advance;
	assign ctl.valid   = valid_s1;
	assign ctl.advance = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Unpack the payload on each transfer.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd          <= s_tuser[CMD_W-1:0];
			item_s1.move_ticks   <= s_tdata[15:0];
			item_s1.move_dir     <= s_tdata[16];
			item_s1.move_speed   <= s_tdata[26:17];
			item_s1.target_index <= s_tdata[30:27];
		end
	end

	// The stage never advances while empty.
	assert property (@(posedge clk) disable iff (!arst_n) advance |-> valid_s1)
		else $error("input stage advanced while empty");

endmodule

// ----- hdl/epmc_core.sv -----
// Move task state, position counting and result register.
module epmc_core #(
	parameter int COUNT_BITS = epmc_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  epmc_pkg::cfg_t       cfg,
	input  epmc_pkg::stage_ctl_t ctl,
	input  epmc_pkg::item_t      item_s1,
	output logic                 advance,
	output logic                 res_valid,
	input  logic                 res_ready,
	output epmc_pkg::result_t    res
);
	import epmc_pkg::*;

	localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

	// True when the signed difference d has magnitude t or more.
	function automatic logic reach(input logic [COUNT_BITS-1:0] d, input logic [15:0] t);
		logic [COUNT_BITS-1:0] mag;
		logic                  hit;
		mag = d[COUNT_BITS-1] ? ~d : d;
		if (t == 16'd0) begin
			hit = 1'b1;
		end else if (d[COUNT_BITS-1]) begin
			hit = (mag >= COUNT_BITS'(t - 16'd1));
		end else begin
			hit = (mag >= COUNT_BITS'(t));
		end
		return hit;
	endfunction

	// Task state. disp holds count minus move start, ext holds count minus
	// the stopped reference; both step together with the count.
	logic [COUNT_BITS-1:0] pos_q, disp_q, ext_q;
	logic [COUNT_BITS-1:0] pos_n, disp_n, ext_n;
	logic [COUNT_BITS-1:0] pos_p, disp_p, ext_p;
	logic [TICKS_W-1:0]    target_q, target_n;
	logic                  active_q, active_n;
	step_t                 step_q, step_n;
	logic [DUTY_W-1:0]     duty_q, duty_n;
	logic                  dir_q, dir_n;
	logic [INDEX_W-1:0]    cur_idx_q, cur_idx_n, pend_idx_q, pend_idx_n;
	logic                  idx_move_q, idx_move_n;
	logic [15:0]           elapsed_q, elapsed_n, elapsed_inc;
	status_t               status_n;

	logic                  out_valid_q;
	result_t               res_q;
	logic [63:0]           pos_wide;

	// Helpers for the move commands.
	logic [DUTY_W-1:0]     speed_sat;
	logic [INDEX_W-1:0]    idx_dist;
	logic [19:0]           prod;
	logic [TICKS_W-1:0]    idx_len;
	logic                  idx_up;

	assign advance   = ctl.valid && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = res_q;

	// Pulse stepping of the count and both differences.
	always_comb begin
		case (step_q)
			STEP_UP: begin
				pos_p  = pos_q + ONE;
				disp_p = disp_q + ONE;
				ext_p  = ext_q + ONE;
			end
			STEP_DOWN: begin
				pos_p  = pos_q - ONE;
				disp_p = disp_q - ONE;
				ext_p  = ext_q - ONE;
			end
			default: begin
				pos_p  = pos_q;
				disp_p = disp_q;
				ext_p  = ext_q;
			end
		endcase
	end

	// Move length and direction for an index move, and duty saturation.
	assign idx_up      = (item_s1.target_index > cur_idx_q);
	assign idx_dist    = idx_up ? item_s1.target_index - cur_idx_q
	                            : cur_idx_q - item_s1.target_index;
	assign prod        = 20'(cfg.step_ticks) * 20'(idx_dist);
	assign idx_len     = (prod[19:16] != 4'd0) ? TICKS_MAX : prod[15:0];
	assign speed_sat   = (item_s1.move_speed > SPEED_SAT) ? 8'd255
	                                                     : item_s1.move_speed[DUTY_W-1:0];
	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

	// Next state for the item in the input register.
	always_comb begin
		pos_n      = pos_q;
		disp_n     = disp_q;
		ext_n      = ext_q;
		target_n   = target_q;
		active_n   = active_q;
		step_n     = step_q;
		duty_n     = duty_q;
		dir_n      = dir_q;
		cur_idx_n  = cur_idx_q;
		pend_idx_n = pend_idx_q;
		idx_move_n = idx_move_q;
		elapsed_n  = elapsed_q;
		status_n   = ST_NONE;
		case (cmd_t'(item_s1.cmd))
			CMD_PULSE: begin
				pos_n  = pos_p;
				disp_n = disp_p;
				ext_n  = ext_p;
				if (active_q) begin
					if (reach(disp_p, target_q)) begin
						duty_n     = '0;
						dir_n      = 1'b0;
						active_n   = 1'b0;
						ext_n      = '0;
						idx_move_n = 1'b0;
						if (idx_move_q) begin
							cur_idx_n = pend_idx_q;
						end
						status_n = ST_DONE;
					end
				end else if (reach(ext_p, cfg.ext_threshold)) begin
					ext_n    = '0;
					status_n = ST_EXTERNAL;
				end
			end
			CMD_MOVE: begin
				idx_move_n = 1'b0;
				if (item_s1.move_ticks == '0) begin
					duty_n   = '0;
					dir_n    = 1'b0;
					active_n = 1'b0;
				end else begin
					target_n  = item_s1.move_ticks;
					disp_n    = '0;
					active_n  = 1'b1;
					elapsed_n = '0;
					duty_n    = speed_sat;
					dir_n     = item_s1.move_dir;
					if (speed_sat != '0) begin
						step_n = item_s1.move_dir ? STEP_UP : STEP_DOWN;
					end
				end
			end
			CMD_GOTO: begin
				if (item_s1.target_index == cur_idx_q) begin
					status_n = ST_AT_INDEX;
				end else if (item_s1.target_index > cfg.max_index) begin
					status_n = ST_REJECTED;
				end else if (idx_len == '0) begin
					duty_n     = '0;
					dir_n      = 1'b0;
					active_n   = 1'b0;
					idx_move_n = 1'b0;
					cur_idx_n  = item_s1.target_index;
					status_n   = ST_DONE;
				end else begin
					target_n   = idx_len;
					disp_n     = '0;
					active_n   = 1'b1;
					elapsed_n  = '0;
					duty_n     = cfg.index_speed;
					dir_n      = !idx_up;
					if (cfg.index_speed != '0) begin
						step_n = idx_up ? STEP_DOWN : STEP_UP;
					end
					idx_move_n = 1'b1;
					pend_idx_n = item_s1.target_index;
				end
			end
			CMD_CANCEL: begin
				active_n   = 1'b0;
				idx_move_n = 1'b0;
			end
			CMD_TICK: begin
				if (active_q) begin
					elapsed_n = elapsed_inc;
					if ((cfg.move_timeout != '0) && (elapsed_inc > cfg.move_timeout)) begin
						duty_n     = '0;
						dir_n      = 1'b0;
						active_n   = 1'b0;
						idx_move_n = 1'b0;
						status_n   = ST_TIMEOUT;
					end
				end else if (reach(ext_q, cfg.ext_threshold)) begin
					ext_n    = '0;
					status_n = ST_EXTERNAL;
				end
			end
			default: ;
		endcase
	end

	assign pos_wide = 64'(pos_n);

	// State update on each advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			disp_q     <= '0;
			ext_q      <= '0;
			target_q   <= '0;
			active_q   <= 1'b0;
			step_q     <= STEP_NONE;
			duty_q     <= '0;
			dir_q      <= 1'b0;
			cur_idx_q  <= '0;
			pend_idx_q <= '0;
			idx_move_q <= 1'b0;
			elapsed_q  <= '0;
		end else if (advance) begin
			pos_q      <= pos_n;
			disp_q     <= disp_n;
			ext_q      <= ext_n;
			target_q   <= target_n;
			active_q   <= active_n;
			step_q     <= step_n;
			duty_q     <= duty_n;
			dir_q      <= dir_n;
			cur_idx_q  <= cur_idx_n;
			pend_idx_q <= pend_idx_n;
			idx_move_q <= idx_move_n;
			elapsed_q  <= elapsed_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.pwm_duty       <= duty_n;
			res_q.dir_pin        <= dir_n;
			res_q.busy_res       <= active_n;
			res_q.status         <= status_n;
			res_q.position_count <= pos_wide[POS_W-1:0];
			res_q.position_index <= cur_idx_n;
		end
	end

	// An index move only exists inside an active task.
	assert property (@(posedge clk) disable iff (!arst_n) !active_q |-> !idx_move_q)
		else $error("index move pending without an active task");

	// A finished or timed out move is no longer busy and has zero duty.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.status == ST_DONE || res_q.status == ST_TIMEOUT)
		|-> !res_q.busy_res && (res_q.pwm_duty == '0))
		else $error("stopped move still drives the motor");

	// External movement is only reported while idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.status == ST_EXTERNAL) |-> !res_q.busy_res)
		else $error("external movement flagged during a move");

	// Flagging external movement takes the count as the new reference.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (status_n == ST_EXTERNAL) |=> (ext_q == '0))
		else $error("reference not updated after external movement");

endmodule

// ----- hdl/encoder_position_move_controller_top.sv -----
// Top level of the encoder position move controller.
//
// Channel | Direction | Contents
// s_*     | in        | one event: tuser cmd, tdata move fields
// m_*     | out       | one result per event: drive, status, position
// cfg_*   | in        | register write: index and 16-bit data
//
// Every event passes through the input register and then the result
// register; a new event is taken in every cycle while results are drained.
// The result register is loaded from the input register once it is free.
// Reset clears the move task and the position count, and sets the config registers to their reset values.
// A stalled result holds the input register, which then stalls the input.
module encoder_position_move_controller_top #(
	parameter int COUNT_BITS = epmc_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] move_ticks, [16] move_dir, [26:17] move_speed,
	// [30:27] target_index, [31] zero
	input  logic [epmc_pkg::S_TDATA_W-1:0]  s_tdata,
	// [2:0] cmd
	input  logic [epmc_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] pwm_duty, [8] dir_pin, [9] busy_res, [12:10] status,
	// [44:13] position_count, [48:45] position_index, [55:49] zero
	output logic [epmc_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [epmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [epmc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import epmc_pkg::*;

	cfg_t       cfg;
	stage_ctl_t ctl;
	item_t      item_s1;
	result_t    res;
	logic       advance;

	epmc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	epmc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.ctl      (ctl),
		.item_s1  (item_s1)
	);

	epmc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ctl       (ctl),
		.item_s1   (item_s1),
		.advance   (advance),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result, padded with zeros to whole bytes.
	assign m_tdata = {7'd0, res};

endmodule

// ----- verif/tb_encoder_position_move_controller_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the encoder position move controller top level.
module tb_encoder_position_move_controller_top;
	import epmc_pkg::*;

	localparam int RAND_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int STALL_LIMIT     = 1000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int RESET_CYCLES    = 12;

	// Command codes the block ignores.
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	localparam result_t IDLE_RES = '0;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} event_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic [S_TUSER_W-1:0]  s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	encoder_position_move_controller_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the controller state and its registers.
	cfg_t               regs;
	logic [POS_W-1:0]   pos_cnt, rest_cnt, origin_cnt;
	logic [TICKS_W-1:0] goal_ticks, elapsed_ms;
	logic               task_on, pin_q, idx_move_on;
	step_t              step_dir;
	logic [DUTY_W-1:0]  duty_q;
	logic [INDEX_W-1:0] cur_idx, pend_idx;

	result_t    pending_results[$];
	event_row_t directed_rows[$];
	int         errors       = 0;
	int         quiet_cycles = 0;
	int         hold_left    = 0;
	bit         idle_on      = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Absolute count difference, taken modulo the counter width and read as signed.
	function automatic longint span(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
		int sd;
		sd = int'(a - b);
		return (sd < 0) ? -longint'(sd) : longint'(sd);
	endfunction

	// A nonzero duty also selects the direction in which pulses count.
	function automatic void set_drive(logic [DUTY_W-1:0] duty, logic dir);
		if (duty != '0)
			step_dir = dir ? STEP_UP : STEP_DOWN;
		duty_q = duty;
		pin_q  = dir;
	endfunction

	function automatic void halt_motor();
		set_drive('0, 1'b0);
		task_on = 1'b0;
	endfunction

	function automatic void launch(logic [TICKS_W-1:0] ticks, logic dir, logic [DUTY_W-1:0] duty);
		goal_ticks = ticks;
		origin_cnt = pos_cnt;
		task_on    = 1'b1;
		elapsed_ms = '0;
		set_drive(duty, dir);
	endfunction

	// Ends the task once the displacement reaches the target.
	function automatic bit arrived();
		if (!task_on || span(pos_cnt, origin_cnt) < longint'(goal_ticks))
			return 1'b0;
		halt_motor();
		rest_cnt = pos_cnt;
		if (idx_move_on)
			cur_idx = pend_idx;
		idx_move_on = 1'b0;
		return 1'b1;
	endfunction

	// Flags movement while idle and takes the count as the new rest point.
	function automatic bit drifted();
		if (task_on || span(pos_cnt, rest_cnt) < longint'(regs.ext_threshold))
			return 1'b0;
		rest_cnt = pos_cnt;
		return 1'b1;
	endfunction

	// Applies one event to the shadow state and returns the result it causes.
	function automatic result_t next_result(item_t it);
		status_t            st;
		logic [INDEX_W-1:0] gap;
		int unsigned        len;
		st = ST_NONE;
		case (it.cmd)
			CMD_PULSE: begin
				if (step_dir == STEP_UP)
					pos_cnt = pos_cnt + 1'b1;
				else if (step_dir == STEP_DOWN)
					pos_cnt = pos_cnt - 1'b1;
				if (task_on) begin
					if (arrived())
						st = ST_DONE;
				end else if (drifted()) begin
					st = ST_EXTERNAL;
				end
			end
			CMD_MOVE: begin
				idx_move_on = 1'b0;
				if (it.move_ticks == '0)
					halt_motor();
				else
					launch(it.move_ticks, it.move_dir,
						(it.move_speed > SPEED_SAT) ? DUTY_W'(SPEED_SAT) : it.move_speed[DUTY_W-1:0]);
			end
			CMD_GOTO: begin
				if (it.target_index == cur_idx) begin
					st = ST_AT_INDEX;
				end else if (it.target_index > regs.max_index) begin
					st = ST_REJECTED;
				end else begin
					gap = (it.target_index > cur_idx) ? it.target_index - cur_idx
						: cur_idx - it.target_index;
					len = regs.step_ticks * gap;
					if (len > TICKS_MAX)
						len = TICKS_MAX;
					if (len == 0) begin
						// Nothing to travel: the index is taken at once.
						halt_motor();
						idx_move_on = 1'b0;
						cur_idx     = it.target_index;
						st          = ST_DONE;
					end else begin
						launch(TICKS_W'(len), it.target_index < cur_idx, regs.index_speed);
						idx_move_on = 1'b1;
						pend_idx    = it.target_index;
					end
				end
			end
			CMD_CANCEL: begin
				task_on     = 1'b0;
				idx_move_on = 1'b0;
			end
			CMD_TICK: begin
				if (task_on) begin
					if (elapsed_ms != TICKS_MAX)
						elapsed_ms = elapsed_ms + 1'b1;
					if (regs.move_timeout != '0 && elapsed_ms > regs.move_timeout) begin
						halt_motor();
						idx_move_on = 1'b0;
						st          = ST_TIMEOUT;
					end
				end else if (drifted()) begin
					st = ST_EXTERNAL;
				end
			end
			default: begin
			end
		endcase
		return {cur_idx, pos_cnt, st, task_on, pin_q, duty_q};
	endfunction

	function automatic void add_row(item_t it, bit typed, result_t want);
		directed_rows.push_back('{it, typed, want});
	endfunction

	// Random event, weighted toward pulses so that moves run to completion.
	function automatic item_t rand_item();
		item_t it;
		int    pick;
		int    len_kind;
		pick            = $urandom_range(0, 99);
		len_kind        = $urandom_range(0, 9);
		it.move_ticks   = TICKS_W'($urandom_range(0, 65535));
		it.move_dir     = 1'($urandom_range(0, 1));
		it.move_speed   = SPEED_W'($urandom_range(0, 1023));
		it.target_index = INDEX_W'($urandom_range(0, 15));
		if (pick < 50) begin
			it.cmd = CMD_PULSE;
		end else if (pick < 65) begin
			it.cmd = CMD_TICK;
		end else if (pick < 78) begin
			it.cmd = CMD_MOVE;
			if (len_kind == 0)
				it.move_ticks = '0;
			else if (len_kind > 2)
				it.move_ticks = TICKS_W'($urandom_range(1, 24));
			if ($urandom_range(0, 7) == 0)
				it.move_speed = '0;
		end else if (pick < 90) begin
			it.cmd = CMD_GOTO;
		end else if (pick < 96) begin
			it.cmd = CMD_CANCEL;
		end else begin
			it.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		end
		return it;
	endfunction

	// Offers one event, records its expected result when the transfer happens.
	task automatic send_item(item_t it, bit typed, result_t want);
		result_t pred;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.cmd;
		s_tdata  <= {1'b0, it.target_index, it.move_speed, it.move_dir, it.move_ticks};
		do @(posedge clk); while (!s_tready);
		pred = next_result(it);
		pending_results.push_back(typed ? want : pred);
	endtask

	// Stops the input and waits until every expected result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_EXT_THRESHOLD: regs.ext_threshold = data;
			REG_STEP_TICKS:    regs.step_ticks    = data;
			REG_MAX_INDEX:     regs.max_index     = data[INDEX_W-1:0];
			REG_INDEX_SPEED:   regs.index_speed   = data[DUTY_W-1:0];
			REG_MOVE_TIMEOUT:  regs.move_timeout  = data;
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(logic [15:0] thr, logic [15:0] steps, logic [15:0] top,
		logic [15:0] duty, logic [15:0] limit);
		write_reg(REG_EXT_THRESHOLD, thr);
		write_reg(REG_STEP_TICKS, steps);
		write_reg(REG_MAX_INDEX, top);
		write_reg(REG_INDEX_SPEED, duty);
		write_reg(REG_MOVE_TIMEOUT, limit);
		cfg_valid <= 1'b0;
	endtask

	// Result side stalls in random bursts.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready  <= 1'b0;
			hold_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Each result transfer is compared with the oldest expected result.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no expected result pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				got  = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (got.pwm_duty != want.pwm_duty) begin
					$error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, got.pwm_duty);
					errors++;
				end
				if (got.dir_pin != want.dir_pin) begin
					$error("dir_pin: expected %0d, actual %0d", want.dir_pin, got.dir_pin);
					errors++;
				end
				if (got.busy_res != want.busy_res) begin
					$error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
					errors++;
				end
				if (got.status != want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					errors++;
				end
				if (got.position_count != want.position_count) begin
					$error("position_count: expected %0d, actual %0d",
						$signed(want.position_count), $signed(got.position_count));
					errors++;
				end
				if (got.position_index != want.position_index) begin
					$error("position_index: expected %0d, actual %0d",
						want.position_index, got.position_index);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// Shadow state after reset.
		regs = {EXT_THRESHOLD_RST, STEP_TICKS_RST, MAX_INDEX_RST, INDEX_SPEED_RST,
			MOVE_TIMEOUT_RST};
		pos_cnt     = '0;
		rest_cnt    = '0;
		origin_cnt  = '0;
		goal_ticks  = '0;
		elapsed_ms  = '0;
		task_on     = 1'b0;
		pin_q       = 1'b0;
		idx_move_on = 1'b0;
		step_dir    = STEP_NONE;
		duty_q      = '0;
		cur_idx     = '0;
		pend_idx    = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed events at the reset settings.
		add_row({CMD_PULSE, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b1, IDLE_RES);
		add_row({CMD_GOTO, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b1,
			{4'd0, 32'd0, ST_AT_INDEX, 1'b0, 1'b0, 8'd0});
		add_row({CMD_GOTO, 16'd0, 1'b0, 10'd0, 4'd15}, 1'b1,
			{4'd0, 32'd0, ST_REJECTED, 1'b0, 1'b0, 8'd0});
		add_row({CMD_UNUSED_HI, 16'hFFFF, 1'b1, 10'd1023, 4'd15}, 1'b1, IDLE_RES);
		add_row({CMD_CANCEL, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b1, IDLE_RES);
		add_row({CMD_TICK, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b1, IDLE_RES);
		add_row({CMD_MOVE, 16'd3, 1'b1, 10'd1023, 4'd0}, 1'b1,
			{4'd0, 32'd0, ST_NONE, 1'b1, 1'b1, 8'd255});
		add_row({CMD_PULSE, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b1,
			{4'd0, 32'd1, ST_NONE, 1'b1, 1'b1, 8'd255});
		add_row({CMD_PULSE, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b1,
			{4'd0, 32'd2, ST_NONE, 1'b1, 1'b1, 8'd255});
		add_row({CMD_PULSE, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b1,
			{4'd0, 32'd3, ST_DONE, 1'b0, 1'b0, 8'd0});
		add_row({CMD_PULSE, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_MOVE, 16'd0, 1'b1, 10'd500, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_MOVE, 16'hFFFF, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_PULSE, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_TICK, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_CANCEL, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_GOTO, 16'd0, 1'b0, 10'd0, 4'd10}, 1'b0, IDLE_RES);
		add_row({CMD_PULSE, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_MOVE, 16'd5, 1'b1, 10'd256, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_GOTO, 16'd0, 1'b0, 10'd0, 4'd1}, 1'b0, IDLE_RES);
		add_row({CMD_TICK, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		add_row({CMD_UNUSED_LO, 16'd0, 1'b0, 10'd0, 4'd0}, 1'b0, IDLE_RES);
		foreach (directed_rows[i])
			send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
		drain();

		// Random phases, each under its own register settings.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				apply_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			else if (ph == 1)
				apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd1);
			else
				apply_settings(16'($urandom_range(0, 24)), 16'($urandom_range(0, 8)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 40)));
			if (ph == RAND_PHASES - 1)
				idle_on = 1'b0;
			repeat (ITEMS_PER_PHASE) send_item(rand_item(), 1'b0, IDLE_RES);
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
